### hw/rtl/pixel_pair_terminal_colour_map_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel pair colour mapper
// Shared property forms, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PIXEL_PAIR_TERMINAL_COLOUR_MAP_DEFINES_SVH
`define PIXEL_PAIR_TERMINAL_COLOUR_MAP_DEFINES_SVH

// same-cycle implication
`define PPCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ppcm_pkg.sv
// ----------------------------------------------------------------------------
// ppcm_pkg
// Types, palette, thresholds and mapping functions for the colour mapper.
// ----------------------------------------------------------------------------
package ppcm_pkg;

   typedef logic [7:0] chan_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } pixel_type;

   typedef struct packed {
      pixel_type bottom;
      pixel_type top;
   } pixel_pair_type;

   // render mode codes
   localparam logic [2:0] MODE_TRUE  = 3'd0;
   localparam logic [2:0] MODE_ANSI  = 3'd1;
   localparam logic [2:0] MODE_CUBE  = 3'd2;
   localparam logic [2:0] MODE_GREY  = 3'd3;
   localparam logic [2:0] MODE_GLYPH = 3'd4;

   localparam int PAL_SIZE = 8;
   localparam int DIST_W   = 18;

   // palette entries, channel order red, green, blue
   localparam chan_type PALETTE [PAL_SIZE][3] = '{
      '{8'h00, 8'h00, 8'h00},
      '{8'hd0, 8'h10, 8'h10},
      '{8'h10, 8'he0, 8'h10},
      '{8'hf7, 8'hf5, 8'h3a},
      '{8'h10, 8'h10, 8'hf0},
      '{8'hfb, 8'h3d, 8'hf8},
      '{8'h10, 8'hf0, 8'hf0},
      '{8'hf0, 8'hf0, 8'hf0}
   };

   localparam chan_type NEAR_BLACK = 8'd30;
   localparam chan_type NEAR_WHITE = 8'd200;
   localparam logic [2:0] CODE_BLACK = 3'd0;
   localparam logic [2:0] CODE_WHITE = 3'd7;

   // smallest channel value reaching each cube level (ch * 5 / 253)
   localparam chan_type CUBE_STEP [5] = '{8'd51, 8'd102, 8'd152, 8'd203, 8'd253};
   localparam logic [7:0] CUBE_BASE = 8'd16;

   // smallest r+g+b reaching each grey step (floor(sum/3) * 10 / 103)
   localparam logic [9:0] GREY_STEP [24] = '{
      10'd33,  10'd63,  10'd93,  10'd126, 10'd156, 10'd186, 10'd219, 10'd249,
      10'd279, 10'd309, 10'd342, 10'd372, 10'd402, 10'd435, 10'd465, 10'd495,
      10'd528, 10'd558, 10'd588, 10'd618, 10'd651, 10'd681, 10'd711, 10'd744
   };
   localparam logic [7:0] GREY_BASE  = 8'd231;
   localparam logic [7:0] GREY_FLOOR = 8'd232;

   localparam int GLYPH_STEPS = 11;
   localparam logic [10:0] GLYPH_DIV = 11'd138;
   localparam logic [6:0] GLYPH_RAMP [GLYPH_STEPS] = '{
      7'd32, 7'd96, 7'd46, 7'd44, 7'd45, 7'd58, 7'd43, 7'd42, 7'd37, 7'd36, 7'd35
   };

   function automatic logic [2:0] cube_level(input chan_type c);
      logic [2:0] lvl;
      lvl = '0;
      for (int k = 0; k < 5; k++) begin
         if (c >= CUBE_STEP[k]) lvl = lvl + 3'd1;
      end
      return lvl;
   endfunction

   function automatic logic [7:0] cube_code(input pixel_type p);
      return CUBE_BASE + 8'(cube_level(p.red)) * 8'd36
           + 8'(cube_level(p.green)) * 8'd6 + 8'(cube_level(p.blue));
   endfunction

   function automatic logic [7:0] grey_code(input pixel_type p);
      logic [9:0] sum;
      logic [4:0] steps;
      sum   = 10'(p.red) + 10'(p.green) + 10'(p.blue);
      steps = '0;
      for (int k = 0; k < 24; k++) begin
         if (sum >= GREY_STEP[k]) steps = steps + 5'd1;
      end
      return (steps == 5'd0) ? GREY_FLOOR : GREY_BASE + 8'(steps);
   endfunction

   function automatic logic [6:0] glyph_char(input pixel_pair_type pp);
      logic [10:0] sum;
      logic [3:0]  idx;
      sum = 11'(pp.top.red) + 11'(pp.top.green) + 11'(pp.top.blue)
          + 11'(pp.bottom.red) + 11'(pp.bottom.green) + 11'(pp.bottom.blue);
      idx = '0;
      // thresholds stop at ten steps, which caps the index
      for (int k = 1; k < GLYPH_STEPS; k++) begin
         if (sum >= GLYPH_DIV * 11'(k)) idx = idx + 4'd1;
      end
      return GLYPH_RAMP[idx];
   endfunction

endpackage

### hw/rtl/ppcm_nearest8.sv
// ----------------------------------------------------------------------------
// ppcm_nearest8
// Nearest eight-colour palette entry by channel-weighted absolute distance.
// ----------------------------------------------------------------------------
module ppcm_nearest8
   import ppcm_pkg::*;
(
   input  pixel_type  pixel,
   output logic [2:0] code
);

   logic [DIST_W-1:0] distance [PAL_SIZE];
   logic [DIST_W-1:0] dist_a [4];
   logic [2:0]        idx_a  [4];
   logic [DIST_W-1:0] dist_b [2];
   logic [2:0]        idx_b  [2];
   logic [2:0]        best;
   chan_type          ch     [3];

   assign ch[0] = pixel.red;
   assign ch[1] = pixel.green;
   assign ch[2] = pixel.blue;

   always_comb begin
      for (int i = 0; i < PAL_SIZE; i++) begin
         distance[i] = '0;
         for (int k = 0; k < 3; k++) begin
            distance[i] = distance[i]
                        + DIST_W'(((PALETTE[i][k] > ch[k]) ? PALETTE[i][k] - ch[k]
                                                           : ch[k] - PALETTE[i][k])
                                  * 16'(ch[k]));
         end
      end
   end

   // compare tree: the right side wins only when strictly closer, so ties keep the lower entry
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (distance[2*i+1] < distance[2*i]) begin
            dist_a[i] = distance[2*i+1];
            idx_a[i]  = 3'(2*i+1);
         end else begin
            dist_a[i] = distance[2*i];
            idx_a[i]  = 3'(2*i);
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (dist_a[2*i+1] < dist_a[2*i]) begin
            dist_b[i] = dist_a[2*i+1];
            idx_b[i]  = idx_a[2*i+1];
         end else begin
            dist_b[i] = dist_a[2*i];
            idx_b[i]  = idx_a[2*i];
         end
      end
      best = (dist_b[1] < dist_b[0]) ? idx_b[1] : idx_b[0];
   end

   always_comb begin
      if (pixel.red < NEAR_BLACK && pixel.green < NEAR_BLACK && pixel.blue < NEAR_BLACK) begin
         code = CODE_BLACK;
      end else if (pixel.red > NEAR_WHITE && pixel.green > NEAR_WHITE
                   && pixel.blue > NEAR_WHITE) begin
         code = CODE_WHITE;
      end else begin
         code = best;
      end
   end

endmodule

### hw/rtl/pixel_pair_terminal_colour_map.sv
// ----------------------------------------------------------------------------
// pixel_pair_terminal_colour_map
// Maps a vertical RGB pixel pair to terminal colour codes and a glyph.
// ----------------------------------------------------------------------------
//  port group   dir  width       contents
//  req_*        in   48 / -      pixel pair word
//  rsp_*        out  24 / 2      colour codes and glyph word, used flags
//  csr_*        in   3           render mode register write
//
//  One pair per cycle sustained while rsp_tready is high; a word taken on req
//  reaches rsp through the input register, then the result register.
//  Reset clears both valid flags and sets the mode to truecolor.
//  A stalled rsp holds its word; the input register still fills, so req
//  stalls only when both registers are full and rsp_tready is low.
module pixel_pair_terminal_colour_map
   import ppcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // [7:0] top_red, [15:8] top_green, [23:16] top_blue,
   // [31:24] bottom_red, [39:32] bottom_green, [47:40] bottom_blue
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] fg_index, [15:8] bg_index, [22:16] glyph_char, [23] zero
   output logic [23:0] rsp_tdata,
   // [0] fg_used, [1] bg_used
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   logic           in_valid_ff;
   pixel_pair_type in_data_ff;
   logic           rsp_valid_ff;
   logic [23:0]    rsp_data_ff;
   logic [1:0]     rsp_user_ff;
   logic [2:0]     mode_ff;

   logic           advance;
   logic [2:0]     ansi_code;
   logic [7:0]     fg_index_in;
   logic [7:0]     bg_index_in;
   logic           fg_used_in;
   logic           bg_used_in;
   logic [23:0]    rsp_data_in;
   logic [1:0]     rsp_user_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   ppcm_nearest8 u_nearest8 (
      .pixel (in_data_ff.top),
      .code  (ansi_code)
   );

   always_comb begin
      fg_used_in  = 1'b0;
      fg_index_in = '0;
      bg_used_in  = 1'b0;
      bg_index_in = '0;
      case (mode_ff)
         MODE_ANSI: begin
            bg_used_in  = 1'b1;
            bg_index_in = 8'(ansi_code);
         end
         MODE_CUBE: begin
            fg_used_in  = 1'b1;
            fg_index_in = cube_code(in_data_ff.top);
            bg_used_in  = 1'b1;
            bg_index_in = cube_code(in_data_ff.bottom);
         end
         MODE_GREY: begin
            fg_used_in  = 1'b1;
            fg_index_in = grey_code(in_data_ff.bottom);
            bg_used_in  = 1'b1;
            bg_index_in = grey_code(in_data_ff.top);
         end
         MODE_TRUE, MODE_GLYPH: begin
            fg_used_in = 1'b0;
            bg_used_in = 1'b0;
         end
         default: begin
            fg_used_in = 1'b0;
            bg_used_in = 1'b0;
         end
      endcase
      rsp_data_in = {1'b0, glyph_char(in_data_ff), bg_index_in, fg_index_in};
      rsp_user_in = {bg_used_in, fg_used_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_TRUE;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) rsp_valid_ff <= in_valid_ff;
         if (csr_wr_en) mode_ff <= csr_wr_data;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_data_ff <= req_tdata;
      if (advance && in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### hw/rtl/ppcm_checker.sv
// ----------------------------------------------------------------------------
// ppcm_checker
// Port-level checks on the colour mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_pair_terminal_colour_map_defines.svh"

module ppcm_checker
   import ppcm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   logic glyph_ok;
   logic unused_ok;

   assign glyph_ok =
      rsp_tdata[22:16] == GLYPH_RAMP[0] || rsp_tdata[22:16] == GLYPH_RAMP[1] ||
      rsp_tdata[22:16] == GLYPH_RAMP[2] || rsp_tdata[22:16] == GLYPH_RAMP[3] ||
      rsp_tdata[22:16] == GLYPH_RAMP[4] || rsp_tdata[22:16] == GLYPH_RAMP[5] ||
      rsp_tdata[22:16] == GLYPH_RAMP[6] || rsp_tdata[22:16] == GLYPH_RAMP[7] ||
      rsp_tdata[22:16] == GLYPH_RAMP[8] || rsp_tdata[22:16] == GLYPH_RAMP[9] ||
      rsp_tdata[22:16] == GLYPH_RAMP[10];

   // an index not in use reads as zero
   assign unused_ok = (rsp_tuser[0] || rsp_tdata[7:0] == 8'd0)
                   && (rsp_tuser[1] || rsp_tdata[15:8] == 8'd0);

   `PPCM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed while stalled")
   `PPCM_ASSERT_NOW(a_glyph_ramp, rsp_tvalid, glyph_ok, "glyph outside brightness ramp")
   `PPCM_ASSERT_NOW(a_unused_zero, rsp_tvalid, unused_ok, "unused index not zero")
   `PPCM_ASSERT_NOW(a_fg_needs_bg, rsp_tvalid && rsp_tuser[0], rsp_tuser[1],
      "foreground used without background")
   `PPCM_ASSERT_NOW(a_ansi_range, rsp_tvalid && rsp_tuser[1] && !rsp_tuser[0],
      rsp_tdata[15:11] == 5'd0, "eight colour code out of range")

endmodule

bind pixel_pair_terminal_colour_map ppcm_checker u_ppcm_checker (.*);

### tb/tb_pixel_pair_terminal_colour_map.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_pair_terminal_colour_map
// Drives pixel pair words through the colour mapper in every render mode,
// predicts the colour codes and glyph of each accepted pair, and compares
// every result word field by field, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_pixel_pair_terminal_colour_map;
   import ppcm_pkg::*;

   // modes without a mapping of their own, which behave like truecolor
   localparam logic [2:0] MODE_RSVD_5 = 3'd5;
   localparam logic [2:0] MODE_RSVD_6 = 3'd6;
   localparam logic [2:0] MODE_RSVD_7 = 3'd7;

   localparam int PHASE_ITEMS = 38;
   localparam int NUM_PHASES  = 12;
   localparam int HOLD_CYCLES = 80;

   // eight colour palette, red in the top byte
   localparam bit [23:0] ANSI_RGB [8] = '{
      24'h000000, 24'hd01010, 24'h10e010, 24'hf7f53a,
      24'h1010f0, 24'hfb3df8, 24'h10f0f0, 24'hf0f0f0
   };
   localparam string SHADES = " `.,-:+*%$#";

   localparam logic [2:0] PHASE_MODE [NUM_PHASES] = '{
      MODE_ANSI, MODE_CUBE, MODE_GREY, MODE_TRUE, MODE_GLYPH, MODE_RSVD_5,
      MODE_RSVD_6, MODE_RSVD_7, MODE_ANSI, MODE_CUBE, MODE_GREY, MODE_ANSI
   };

   typedef struct {
      bit       fg_used;
      bit [7:0] fg_index;
      bit       bg_used;
      bit [7:0] bg_index;
      bit [6:0] glyph;
   } codes_type;

   class colour_code_predictor;
      logic [2:0] mode;
      codes_type  pending_codes[$];
      int         mismatch_count;

      function new();
         mode           = MODE_TRUE;
         mismatch_count = 0;
      endfunction

      function bit [7:0] ansi_code(pixel_type p);
         int unsigned ch[3];
         int unsigned pal, pal_dist, best_dist;
         bit [7:0]    best;
         ch = '{p.red, p.green, p.blue};
         if (ch[0] < 30 && ch[1] < 30 && ch[2] < 30) return 8'(CODE_BLACK);
         if (ch[0] > 200 && ch[1] > 200 && ch[2] > 200) return 8'(CODE_WHITE);
         best      = 0;
         best_dist = 0;
         for (int i = 0; i < 8; i++) begin
            pal_dist = 0;
            for (int k = 0; k < 3; k++) begin
               pal       = ANSI_RGB[i][23 - 8*k -: 8];
               pal_dist += ((pal > ch[k]) ? pal - ch[k] : ch[k] - pal) * ch[k];
            end
            // strict compare keeps the lowest entry on a tie
            if (i == 0 || pal_dist < best_dist) begin
               best_dist = pal_dist;
               best      = 8'(i);
            end
         end
         return best;
      endfunction

      function bit [7:0] cube_index(pixel_type p);
         return 8'(16 + 36 * (int'(p.red) * 5 / 253) + 6 * (int'(p.green) * 5 / 253)
                   + int'(p.blue) * 5 / 253);
      endfunction

      function bit [7:0] grey_index(pixel_type p);
         int avg, code;
         avg  = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
         code = 231 + avg * 10 / 103;
         return 8'((code < 232) ? 232 : code);
      endfunction

      function void note_pair(pixel_pair_type pp);
         codes_type c;
         int        shade;
         c = '{default: 0};
         case (mode)
            MODE_ANSI: begin
               c.bg_used  = 1'b1;
               c.bg_index = ansi_code(pp.top);
            end
            MODE_CUBE: begin
               c.fg_used  = 1'b1;
               c.fg_index = cube_index(pp.top);
               c.bg_used  = 1'b1;
               c.bg_index = cube_index(pp.bottom);
            end
            MODE_GREY: begin
               c.bg_used  = 1'b1;
               c.bg_index = grey_index(pp.top);
               c.fg_used  = 1'b1;
               c.fg_index = grey_index(pp.bottom);
            end
            default: ;
         endcase
         shade = (int'(pp.top.red) + int'(pp.top.green) + int'(pp.top.blue)
                + int'(pp.bottom.red) + int'(pp.bottom.green) + int'(pp.bottom.blue)) / 138;
         if (shade > 10) shade = 10;
         c.glyph = 7'(SHADES[shade]);
         pending_codes.push_back(c);
      endfunction

      function void field_check(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_codes(logic [23:0] data, logic [1:0] user);
         codes_type want;
         if (pending_codes.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual data %h user %b",
                     $time, data, user);
            mismatch_count++;
            return;
         end
         want = pending_codes.pop_front();
         field_check("fg_used", 8'(want.fg_used), 8'(user[0]));
         field_check("fg_index", want.fg_index, data[7:0]);
         field_check("bg_used", 8'(want.bg_used), 8'(user[1]));
         field_check("bg_index", want.bg_index, data[15:8]);
         field_check("glyph_char", 8'(want.glyph), 8'(data[22:16]));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic [47:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en;
   logic [2:0]  csr_wr_data;

   colour_code_predictor codes_model = new();
   int sender_idle_pct = 0;
   int sink_stall_pct  = 0;
   bit hold_phase      = 1'b0;
   logic hold_active   = 1'b0;

   pixel_pair_terminal_colour_map u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("pixel_pair_terminal_colour_map test failed");
      $finish;
   end

   // sink: random stalls, or a long hold-off to back the block up
   always @(posedge clock) begin
      if (reset || hold_active) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   initial begin
      wait (hold_phase == 1'b1);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         codes_model.check_codes(rsp_tdata, rsp_tuser);
   end

   function automatic pixel_type mk_pixel(int r, int g, int b);
      pixel_type p;
      p.red   = 8'(r);
      p.green = 8'(g);
      p.blue  = 8'(b);
      return p;
   endfunction

   function automatic int clamp_chan(int v);
      return (v < 0) ? 0 : (v > 255) ? 255 : v;
   endfunction

   function automatic pixel_type random_pixel();
      int unsigned kind, entry, v;
      int          step_vals[10];
      step_vals = '{50, 51, 101, 102, 151, 152, 202, 203, 252, 253};
      kind = $urandom_range(9);
      case (kind)
         4: return mk_pixel($urandom_range(35), $urandom_range(35), $urandom_range(35));
         5: return mk_pixel($urandom_range(255, 195), $urandom_range(255, 195),
                            $urandom_range(255, 195));
         6: begin
            entry = $urandom_range(7);
            return mk_pixel(
               clamp_chan(int'(ANSI_RGB[entry][23:16]) + int'($urandom_range(24)) - 12),
               clamp_chan(int'(ANSI_RGB[entry][15:8]) + int'($urandom_range(24)) - 12),
               clamp_chan(int'(ANSI_RGB[entry][7:0]) + int'($urandom_range(24)) - 12));
         end
         7: return mk_pixel($urandom_range(1) * 255, $urandom_range(1) * 255,
                            $urandom_range(1) * 255);
         8: return mk_pixel(step_vals[$urandom_range(9)], step_vals[$urandom_range(9)],
                            step_vals[$urandom_range(9)]);
         9: begin
            v = $urandom_range(255);
            return mk_pixel(v, v, clamp_chan(int'(v) + int'($urandom_range(2)) - 1));
         end
         default: return mk_pixel($urandom_range(255), $urandom_range(255),
                                  $urandom_range(255));
      endcase
   endfunction

   task automatic send_pair(pixel_pair_type pp);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= pp;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      codes_model.note_pair(pp);
   endtask

   task automatic send_rgb(int tr, int tg, int tb, int br, int bg, int bb);
      pixel_pair_type pp;
      pp.top    = mk_pixel(tr, tg, tb);
      pp.bottom = mk_pixel(br, bg, bb);
      send_pair(pp);
   endtask

   // drop valid, let every result come back, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (codes_model.pending_codes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(logic [2:0] m);
      csr_wr_data <= m;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      codes_model.mode = m;
   endtask

   initial begin
      pixel_pair_type pp;
      reset       <= 1'b1;
      req_tdata   <= '0;
      req_tvalid  <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= MODE_TRUE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // palette shortcuts, exact palette entries, glyph extremes
      write_mode(MODE_ANSI);
      send_rgb(0, 0, 0, 0, 0, 0);
      send_rgb(29, 29, 29, 255, 255, 255);
      send_rgb(30, 29, 29, 0, 0, 0);
      send_rgb(201, 201, 201, 0, 0, 0);
      send_rgb(200, 255, 255, 255, 255, 255);
      send_rgb(255, 255, 255, 255, 255, 255);
      for (int i = 1; i < 8; i++)
         send_rgb(ANSI_RGB[i][23:16], ANSI_RGB[i][15:8], ANSI_RGB[i][7:0], 128, 64, 32);
      wait_idle();

      // cube level boundaries
      write_mode(MODE_CUBE);
      send_rgb(50, 51, 252, 253, 255, 0);
      send_rgb(101, 102, 151, 152, 202, 203);
      wait_idle();

      // grey floor and top of ramp
      write_mode(MODE_GREY);
      send_rgb(0, 0, 0, 33, 0, 0);
      send_rgb(255, 255, 255, 34, 34, 35);
      wait_idle();

      write_mode(MODE_RSVD_7);
      send_rgb(255, 0, 255, 0, 255, 0);
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 63; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 63; end
            default: begin sender_idle_pct = 33; sink_stall_pct = 33; end
         endcase
         write_mode(PHASE_MODE[ph]);
         if (ph == 4) hold_phase = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pp.top    = random_pixel();
            pp.bottom = random_pixel();
            send_pair(pp);
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (codes_model.mismatch_count == 0 && codes_model.pending_codes.size() == 0)
         $display("pixel_pair_terminal_colour_map test passed");
      else
         $display("pixel_pair_terminal_colour_map test failed");
      $finish;
   end

endmodule
